[src/tacs_pkg.sv]
package tacs_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 16;
  localparam int FUNC_W        = 2;
  localparam int OPC_W         = 4;
  localparam int DIV_STEPS     = 8;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  // host item functions
  localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_EXEC  = 2'd2;

  typedef enum logic [OPC_W-1:0] {
    OP_HALT,
    OP_LDA_ABS,
    OP_LDA_IMM,
    OP_LDB_ABS,
    OP_LDB_IMM,
    OP_LDT,
    OP_STA,
    OP_STB,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD,
    OP_CMP,
    OP_JEQ,
    OP_JNE
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HRD,
    ST_OP,
    ST_B1,
    ST_B2,
    ST_DATA,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

[src/tacs_in_if.sv]
interface tacs_in_if
  import tacs_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [WORD_W-1:0] address;
  logic [BYTE_W-1:0] data;

  modport source (output valid, output func, output address, output data, input ready);
  modport sink   (input valid, input func, input address, input data, output ready);
endinterface

[src/tacs_out_if.sv]
interface tacs_out_if
  import tacs_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;
  logic [BYTE_W-1:0] acc_value;
  logic [BYTE_W-1:0] operand_value;
  logic [WORD_W-1:0] jump_target;
  logic [WORD_W-1:0] prog_counter;
  logic              halted;
  logic              div_error;

  modport source (
    output valid, output read_data, output acc_value, output operand_value,
    output jump_target, output prog_counter, output halted, output div_error,
    input ready
  );
  modport sink (
    input valid, input read_data, input acc_value, input operand_value,
    input jump_target, input prog_counter, input halted, input div_error,
    output ready
  );
endinterface

[src/tacs_ram.sv]
module tacs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/tiny_accumulator_cpu_step.sv]
// a host write goes straight to the done state, a host read passes the memory read state;
// execute fetches the opcode and operand bytes; divide and modulo run a bit-serial divider
// one item at a time on a single-port byte memory with a registered read port
// a new item is taken while the previous result still waits at the output register
// synchronous active-low reset zeroes pc, accumulator, operand, target and output valid,
// then sweeps the memory to zero address by address, during which no item is taken
module tiny_accumulator_cpu_step
  import tacs_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tacs_in_if.sink    in_ch,
  tacs_out_if.source out_ch
);

  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  state_t state_r, state_nxt;

  logic [BYTE_W-1:0]    acc_r, acc_nxt;
  logic [BYTE_W-1:0]    opnd_r, opnd_nxt;
  logic [WORD_W-1:0]    tgt_r, tgt_nxt;
  logic [WORD_W-1:0]    pc_r, pc_nxt;
  op_t                  op_r, op_nxt;
  logic [BYTE_W-1:0]    hi_r, hi_nxt;
  logic [BYTE_W-1:0]    rdbyte_r, rdbyte_nxt;
  logic                 halt_r, halt_nxt;
  logic                 derr_r, derr_nxt;
  logic [BYTE_W-1:0]    rem_r, rem_nxt;
  logic [BYTE_W-1:0]    quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [ADDR_BITS-1:0] clr_cnt_r, clr_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    o_rd_r, o_rd_nxt;
  logic [BYTE_W-1:0]    o_acc_r, o_acc_nxt;
  logic [BYTE_W-1:0]    o_opnd_r, o_opnd_nxt;
  logic [WORD_W-1:0]    o_tgt_r, o_tgt_nxt;
  logic [WORD_W-1:0]    o_pc_r, o_pc_nxt;
  logic                 o_halt_r, o_halt_nxt;
  logic                 o_derr_r, o_derr_nxt;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [BYTE_W-1:0]    ram_wdata;
  logic [BYTE_W-1:0]    ram_rdata;

  logic                 in_acc;
  logic                 out_take;
  logic                 out_free;
  op_t                  opc;
  logic [WORD_W-1:0]    word;
  logic [WORD_W-1:0]    pc_inc;
  logic [WORD_W-1:0]    prod;
  logic [BYTE_W:0]      rem_sh;
  logic                 div_ge;
  logic [BYTE_W-1:0]    rem_step;
  logic [BYTE_W-1:0]    quo_step;

  tacs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_take    = out_valid_r && out_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_data     = o_rd_r;
  assign out_ch.acc_value     = o_acc_r;
  assign out_ch.operand_value = o_opnd_r;
  assign out_ch.jump_target   = o_tgt_r;
  assign out_ch.prog_counter  = o_pc_r;
  assign out_ch.halted        = o_halt_r;
  assign out_ch.div_error     = o_derr_r;

  assign opc    = op_t'(ram_rdata[OPC_W-1:0]);
  assign word   = {hi_r, ram_rdata};
  assign pc_inc = WORD_W'(pc_r + 16'd1);
  assign prod   = WORD_W'(acc_r * opnd_r);

  // one restoring divide step per cycle, dividend shifted in msb first
  assign rem_sh   = {rem_r, quo_r[BYTE_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, opnd_r});
  assign rem_step = div_ge ? BYTE_W'(rem_sh - {1'b0, opnd_r}) : rem_sh[BYTE_W-1:0];
  assign quo_step = {quo_r[BYTE_W-2:0], div_ge};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.func)
            FN_WRITE: state_nxt = ST_DONE;
            FN_READ:  state_nxt = ST_HRD;
            FN_EXEC:  state_nxt = ST_OP;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_HRD: state_nxt = ST_DONE;
      ST_OP: begin
        unique case (opc)
          OP_LDA_ABS, OP_LDA_IMM, OP_LDB_ABS, OP_LDB_IMM,
          OP_LDT, OP_STA, OP_STB: state_nxt = ST_B1;
          OP_DIV, OP_MOD: state_nxt = (opnd_r == '0) ? ST_DONE : ST_DIV;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_B1: begin
        state_nxt = (op_r == OP_LDA_IMM || op_r == OP_LDB_IMM) ? ST_DONE : ST_B2;
      end
      ST_B2: begin
        state_nxt = (op_r == OP_LDA_ABS || op_r == OP_LDB_ABS) ? ST_DATA : ST_DONE;
      end
      ST_DATA: state_nxt = ST_DONE;
      ST_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    acc_nxt     = acc_r;
    opnd_nxt    = opnd_r;
    tgt_nxt     = tgt_r;
    pc_nxt      = pc_r;
    op_nxt      = op_r;
    hi_nxt      = hi_r;
    rdbyte_nxt  = rdbyte_r;
    halt_nxt    = halt_r;
    derr_nxt    = derr_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    div_cnt_nxt = div_cnt_r;
    clr_cnt_nxt = clr_cnt_r;

    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    o_rd_nxt      = o_rd_r;
    o_acc_nxt     = o_acc_r;
    o_opnd_nxt    = o_opnd_r;
    o_tgt_nxt     = o_tgt_r;
    o_pc_nxt      = o_pc_r;
    o_halt_nxt    = o_halt_r;
    o_derr_nxt    = o_derr_r;

    ram_we    = 1'b0;
    ram_addr  = pc_r[ADDR_BITS-1:0];
    ram_wdata = '0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_addr    = clr_cnt_r;
        clr_cnt_nxt = ADDR_BITS'(clr_cnt_r + 1'b1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          rdbyte_nxt = '0;
          halt_nxt   = 1'b0;
          derr_nxt   = 1'b0;
          unique case (in_ch.func)
            FN_WRITE: begin
              ram_we    = 1'b1;
              ram_addr  = in_ch.address[ADDR_BITS-1:0];
              ram_wdata = in_ch.data;
            end
            FN_READ: ram_addr = in_ch.address[ADDR_BITS-1:0];
            FN_EXEC: pc_nxt = pc_inc;
            default: ;
          endcase
        end
      end
      ST_HRD: rdbyte_nxt = ram_rdata;
      ST_OP: begin
        op_nxt = opc;
        unique case (opc)
          OP_HALT: halt_nxt = 1'b1;
          OP_LDA_ABS, OP_LDA_IMM, OP_LDB_ABS, OP_LDB_IMM,
          OP_LDT, OP_STA, OP_STB: pc_nxt = pc_inc;
          OP_ADD: acc_nxt = BYTE_W'(acc_r + opnd_r);
          OP_SUB: acc_nxt = BYTE_W'(acc_r - opnd_r);
          OP_MUL: acc_nxt = prod[BYTE_W-1:0];
          OP_DIV, OP_MOD: begin
            if (opnd_r == '0) begin
              derr_nxt = 1'b1;
            end else begin
              rem_nxt     = '0;
              quo_nxt     = acc_r;
              div_cnt_nxt = '0;
            end
          end
          OP_CMP: begin
            if (acc_r < opnd_r)      acc_nxt = 8'd0;
            else if (acc_r > opnd_r) acc_nxt = 8'd2;
            else                     acc_nxt = 8'd1;
          end
          OP_JEQ: begin
            if (acc_r == 8'd1) pc_nxt = tgt_r;
          end
          OP_JNE: begin
            if (acc_r != 8'd1) pc_nxt = tgt_r;
          end
          default: ;
        endcase
      end
      ST_B1: begin
        if (op_r == OP_LDA_IMM) begin
          acc_nxt = ram_rdata;
        end else if (op_r == OP_LDB_IMM) begin
          opnd_nxt = ram_rdata;
        end else begin
          // high byte of the absolute operand, fetch the low byte next
          hi_nxt = ram_rdata;
          pc_nxt = pc_inc;
        end
      end
      ST_B2: begin
        ram_addr = word[ADDR_BITS-1:0];
        if (op_r == OP_LDT) begin
          tgt_nxt = word;
        end else if (op_r == OP_STA) begin
          ram_we    = 1'b1;
          ram_wdata = acc_r;
        end else if (op_r == OP_STB) begin
          ram_we    = 1'b1;
          ram_wdata = opnd_r;
        end
      end
      ST_DATA: begin
        if (op_r == OP_LDA_ABS) acc_nxt = ram_rdata;
        else                    opnd_nxt = ram_rdata;
      end
      ST_DIV: begin
        rem_nxt     = rem_step;
        quo_nxt     = quo_step;
        div_cnt_nxt = DIV_CNT_W'(div_cnt_r + 1'b1);
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          acc_nxt = (op_r == OP_DIV) ? quo_step : rem_step;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_rd_nxt      = rdbyte_r;
          o_acc_nxt     = acc_r;
          o_opnd_nxt    = opnd_r;
          o_tgt_nxt     = tgt_r;
          o_pc_nxt      = pc_r;
          o_halt_nxt    = halt_r;
          o_derr_nxt    = derr_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      opnd_r      <= '0;
      tgt_r       <= '0;
      pc_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      opnd_r      <= opnd_nxt;
      tgt_r       <= tgt_nxt;
      pc_r        <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    hi_r      <= hi_nxt;
    rdbyte_r  <= rdbyte_nxt;
    halt_r    <= halt_nxt;
    derr_r    <= derr_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    div_cnt_r <= div_cnt_nxt;
    o_rd_r    <= o_rd_nxt;
    o_acc_r   <= o_acc_nxt;
    o_opnd_r  <= o_opnd_nxt;
    o_tgt_r   <= o_tgt_nxt;
    o_pc_r    <= o_pc_nxt;
    o_halt_r  <= o_halt_nxt;
    o_derr_r  <= o_derr_nxt;
  end

endmodule
